// ===== rtl/assert_macros.svh =====
// assertion macros used by the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, idle while reset is asserted
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion that also runs during reset
`define CHK_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mse_pkg.sv =====
// types, opcodes and status codes of the mips subset execute block
// no dependencies
`default_nettype none

package mse_pkg;

    typedef logic [31:0] t_word;
    typedef logic [4:0]  t_reg_idx;
    typedef logic [5:0]  t_code6;

    // data store depth, a power of two
    localparam int DATA_WORDS = 32;
    localparam int DS_AW      = $clog2(DATA_WORDS);
    localparam int RF_WORDS   = 32;

    localparam t_code6 OP_RTYPE = 6'h00;
    localparam t_code6 OP_ADDI  = 6'h08;
    localparam t_code6 OP_ANDI  = 6'h0C;
    localparam t_code6 OP_ORI   = 6'h0D;
    localparam t_code6 OP_LW    = 6'h23;
    localparam t_code6 OP_SW    = 6'h2B;

    localparam t_code6 FN_SLL = 6'h00;
    localparam t_code6 FN_ADD = 6'h20;
    localparam t_code6 FN_AND = 6'h24;
    localparam t_code6 FN_OR  = 6'h25;
    localparam t_code6 FN_NOR = 6'h27;

    localparam t_word SYSCALL_WORD = 32'h0000_000C;

    typedef logic [1:0] t_status;
    localparam t_status ST_EXEC  = 2'd0;
    localparam t_status ST_UNSUP = 2'd1;
    localparam t_status ST_HALT  = 2'd2;

    // output tdata layout
    localparam int OUT_BITS = 48;
    localparam int O_ST_LO  = 0;
    localparam int O_DST_LO = 2;
    localparam int O_WR     = 7;
    localparam int O_VAL_LO = 8;
    localparam int O_STORED = 40;

    typedef struct packed {
        t_status  status;
        t_reg_idx dest;
        logic     wrote;
        t_word    value;
        logic     stored;
        logic     is_load;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/mips_subset_execute.sv =====
// mips subset execute: three register stages (input, operand, result)
// an instruction moves through the input, operand and result registers in turn;
// throughput: one instruction per cycle while the output is not stalled, set by the single execute stage
// with write-back forwarded into it and snooped into the operand register
// reset: synchronous, empties all stages and clears the valid bits of the
// register file and the data store
// depends on mse_pkg
`default_nettype none

module mips_subset_execute (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] instruction
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] status, [6:2] dest_reg, [7] wrote_reg, [39:8] result_value,
    // [40] stored, [47:41] zero
    output logic [47:0]      m_axis_tdata
);

    // stage valids and payload
    logic                   r1_valid, r2_valid, r3_valid;
    mse_pkg::t_word         r1_instr, r2_instr;
    mse_pkg::t_word         r_a, r_b;
    mse_pkg::t_result       r3_res;
    mse_pkg::t_word         r_ld_data;
    logic                   r_wb_pend;

    // stores
    mse_pkg::t_word                        r_rf [mse_pkg::RF_WORDS];
    logic [mse_pkg::RF_WORDS-1:0]          r_rf_valid;
    mse_pkg::t_word                        r_ds [mse_pkg::DATA_WORDS];
    logic [mse_pkg::DATA_WORDS-1:0]        r_ds_valid;

    logic en1, en2, en3, move23;
    mse_pkg::t_word   wb_data;
    mse_pkg::t_reg_idx rs1, rt1, rs2, rt2;
    mse_pkg::t_word   a, b;
    mse_pkg::t_result n_res;
    logic [mse_pkg::DS_AW-1:0] ds_addr;

    assign en3    = !r3_valid || m_axis_tready;
    assign move23 = en3 && r2_valid;
    assign en2    = !r2_valid || en3;
    assign en1    = !r1_valid || en2;
    assign s_axis_tready = en1;

    assign wb_data = r3_res.is_load ? r_ld_data : r3_res.value;

    assign rs1 = r1_instr[25:21];
    assign rt1 = r1_instr[20:16];
    assign rs2 = r2_instr[25:21];
    assign rt2 = r2_instr[20:16];

    // forward the write-back that lands at the end of this cycle
    assign a = (r_wb_pend && (r3_res.dest == rs2)) ? wb_data : r_a;
    assign b = (r_wb_pend && (r3_res.dest == rt2)) ? wb_data : r_b;

    // execute
    always_comb begin
        logic [5:0]  op, funct;
        logic [4:0]  rd, shamt;
        logic [15:0] imm;
        mse_pkg::t_word sext, zext, r, sum;
        logic rtype, itype;
        op    = r2_instr[31:26];
        funct = r2_instr[5:0];
        rd    = r2_instr[15:11];
        shamt = r2_instr[10:6];
        imm   = r2_instr[15:0];
        sext  = {{16{imm[15]}}, imm};
        zext  = {16'h0000, imm};
        sum   = a + sext;
        r     = '0;
        rtype = 1'b0;
        itype = 1'b0;
        n_res = '0;
        n_res.status = mse_pkg::ST_EXEC;
        if (r2_instr == mse_pkg::SYSCALL_WORD) begin
            n_res.status = mse_pkg::ST_HALT;
        end else if (op == mse_pkg::OP_RTYPE) begin
            rtype = 1'b1;
            case (funct)
                mse_pkg::FN_ADD: r = a + b;
                mse_pkg::FN_AND: r = a & b;
                mse_pkg::FN_OR:  r = a | b;
                mse_pkg::FN_NOR: r = ~(a | b);
                mse_pkg::FN_SLL: r = b << shamt;
                default: begin
                    rtype = 1'b0;
                    n_res.status = mse_pkg::ST_UNSUP;
                end
            endcase
        end else begin
            itype = 1'b1;
            case (op)
                mse_pkg::OP_ADDI: r = sum;
                mse_pkg::OP_ANDI: r = a & zext;
                mse_pkg::OP_ORI:  r = a | zext;
                mse_pkg::OP_LW:   n_res.is_load = 1'b1;
                mse_pkg::OP_SW: begin
                    itype = 1'b0;
                    n_res.value  = b;
                    n_res.stored = 1'b1;
                end
                default: begin
                    itype = 1'b0;
                    n_res.status = mse_pkg::ST_UNSUP;
                end
            endcase
        end
        if (rtype) begin
            n_res.dest  = rd;
            n_res.value = r;
            n_res.wrote = (rd != '0);
        end else if (itype) begin
            n_res.dest  = rt2;
            n_res.value = r;
            n_res.wrote = (rt2 != '0);
        end
        ds_addr = sum[mse_pkg::DS_AW-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid   <= 1'b0;
            r2_valid   <= 1'b0;
            r3_valid   <= 1'b0;
            r_wb_pend  <= 1'b0;
            r_rf_valid <= '0;
            r_ds_valid <= '0;
        end else begin
            if (en1) r1_valid <= s_axis_tvalid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
            r_wb_pend <= move23 && n_res.wrote;
            if (r_wb_pend) r_rf_valid[r3_res.dest] <= 1'b1;
            if (move23 && n_res.stored) r_ds_valid[ds_addr] <= 1'b1;
        end
    end

    // payload and stores
    always_ff @(posedge i_clk) begin
        if (en1) r1_instr <= s_axis_tdata;
        if (en2) begin
            r2_instr <= r1_instr;
            if (r_wb_pend && (r3_res.dest == rs1)) r_a <= wb_data;
            else r_a <= r_rf_valid[rs1] ? r_rf[rs1] : '0;
            if (r_wb_pend && (r3_res.dest == rt1)) r_b <= wb_data;
            else r_b <= r_rf_valid[rt1] ? r_rf[rt1] : '0;
        end else begin
            // keep held operands current with the register file
            if (r_wb_pend && (r3_res.dest == rs2)) r_a <= wb_data;
            if (r_wb_pend && (r3_res.dest == rt2)) r_b <= wb_data;
        end
        if (r_wb_pend) r_rf[r3_res.dest] <= wb_data;
        if (move23) begin
            r3_res    <= n_res;
            r_ld_data <= r_ds_valid[ds_addr] ? r_ds[ds_addr] : '0;
            if (n_res.stored) r_ds[ds_addr] <= b;
        end
    end

    assign m_axis_tvalid = r3_valid;
    assign m_axis_tdata  = {7'b0, r3_res.stored, wb_data, r3_res.wrote,
                            r3_res.dest, r3_res.status};

endmodule

`default_nettype wire

// ===== rtl/mse_checker.sv =====
// port-level checks for mips_subset_execute, bound into every instance of it
// depends on mse_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module mse_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [31:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);

    logic [1:0] st;
    logic       wr, sto;
    logic [4:0] dst;

    assign st  = m_axis_tdata[mse_pkg::O_ST_LO +: 2];
    assign dst = m_axis_tdata[mse_pkg::O_DST_LO +: 5];
    assign wr  = m_axis_tdata[mse_pkg::O_WR];
    assign sto = m_axis_tdata[mse_pkg::O_STORED];

    // stalled result transfer holds
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `CHK_ASSERT(a_status_code, i_clk, i_rst_n, m_axis_tvalid |-> (st == mse_pkg::ST_EXEC || st == mse_pkg::ST_UNSUP || st == mse_pkg::ST_HALT), "bad status code")
    `CHK_ASSERT(a_store_only, i_clk, i_rst_n, m_axis_tvalid && sto |-> st == mse_pkg::ST_EXEC && !wr, "store with register write")
    `CHK_ASSERT(a_wr_nonzero, i_clk, i_rst_n, m_axis_tvalid && wr |-> st == mse_pkg::ST_EXEC && dst != 5'd0, "write to register zero")
    `CHK_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind mips_subset_execute mse_checker u_mse_checker (.*);

`default_nettype wire

// ===== tb/mips_subset_execute_checker.sv =====
// checker for the mips subset execute block: watches both stream channels,
// keeps its own register file and data store, compares every result
// depends on mse_pkg

module mips_subset_execute_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    // [31:0] instruction
    input  logic [31:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    // [1:0] status, [6:2] dest_reg, [7] wrote_reg, [39:8] result_value,
    // [40] stored, [47:41] zero
    input  logic [47:0] i_out_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    typedef struct packed {
        mse_pkg::t_status  status;
        mse_pkg::t_reg_idx dest;
        logic              wrote;
        mse_pkg::t_word    value;
        logic              stored;
    } t_exec_out;

    mse_pkg::t_word gpr [mse_pkg::RF_WORDS];
    mse_pkg::t_word dmem [mse_pkg::DATA_WORDS];
    t_exec_out      writeback_q [$];
    int             fail_cnt = 0;
    int             checked_cnt = 0;

    // runs one instruction against the shadow state and returns its result
    function automatic t_exec_out execute_word(input mse_pkg::t_word w);
        mse_pkg::t_code6   op;
        mse_pkg::t_code6   funct;
        mse_pkg::t_reg_idx rs;
        mse_pkg::t_reg_idx rt;
        mse_pkg::t_reg_idx rd;
        mse_pkg::t_reg_idx target;
        logic [4:0]        shamt;
        logic [15:0]       imm;
        mse_pkg::t_word    a;
        mse_pkg::t_word    b;
        mse_pkg::t_word    r;
        mse_pkg::t_word    addr_sum;
        logic              writes;
        t_exec_out         res;
        op       = w[31:26];
        rs       = w[25:21];
        rt       = w[20:16];
        rd       = w[15:11];
        shamt    = w[10:6];
        funct    = w[5:0];
        imm      = w[15:0];
        a        = (rs == '0) ? '0 : gpr[rs];
        b        = (rt == '0) ? '0 : gpr[rt];
        addr_sum = a + {{16{imm[15]}}, imm};
        r        = '0;
        writes   = 1'b0;
        target   = '0;
        res      = '0;
        res.status = mse_pkg::ST_EXEC;
        if (w == mse_pkg::SYSCALL_WORD) begin
            res.status = mse_pkg::ST_HALT;
        end else if (op == mse_pkg::OP_RTYPE) begin
            writes = 1'b1;
            target = rd;
            case (funct)
                mse_pkg::FN_ADD: r = a + b;
                mse_pkg::FN_AND: r = a & b;
                mse_pkg::FN_OR:  r = a | b;
                mse_pkg::FN_NOR: r = ~(a | b);
                mse_pkg::FN_SLL: r = b << shamt;
                default: begin
                    writes     = 1'b0;
                    res.status = mse_pkg::ST_UNSUP;
                end
            endcase
        end else begin
            target = rt;
            case (op)
                mse_pkg::OP_ADDI: begin
                    writes = 1'b1;
                    r      = addr_sum;
                end
                mse_pkg::OP_ANDI: begin
                    writes = 1'b1;
                    r      = a & {16'h0000, imm};
                end
                mse_pkg::OP_ORI: begin
                    writes = 1'b1;
                    r      = a | {16'h0000, imm};
                end
                mse_pkg::OP_LW: begin
                    writes = 1'b1;
                    r      = dmem[addr_sum[mse_pkg::DS_AW-1:0]];
                end
                mse_pkg::OP_SW: begin
                    dmem[addr_sum[mse_pkg::DS_AW-1:0]] = b;
                    res.value  = b;
                    res.stored = 1'b1;
                end
                default: res.status = mse_pkg::ST_UNSUP;
            endcase
        end
        if (writes) begin
            res.dest  = target;
            res.value = r;
            // writes aimed at register zero are dropped
            if (target != '0) begin
                gpr[target] = r;
                res.wrote   = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic check_field(input string what, input mse_pkg::t_word want,
                               input mse_pkg::t_word got);
        if (want !== got) begin
            fail_cnt++;
            $display("%0t: %s expected %h got %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_exec_out want;
        t_exec_out got;
        if (!i_rst_n) begin
            foreach (gpr[i]) gpr[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            writeback_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.status = i_out_data[mse_pkg::O_ST_LO +: 2];
                got.dest   = i_out_data[mse_pkg::O_DST_LO +: 5];
                got.wrote  = i_out_data[mse_pkg::O_WR];
                got.value  = i_out_data[mse_pkg::O_VAL_LO +: 32];
                got.stored = i_out_data[mse_pkg::O_STORED];
                if (writeback_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: result expected none got %h", $time, i_out_data);
                end else begin
                    want = writeback_q.pop_front();
                    checked_cnt++;
                    check_field("status", mse_pkg::t_word'(want.status),
                                mse_pkg::t_word'(got.status));
                    check_field("dest_reg", mse_pkg::t_word'(want.dest),
                                mse_pkg::t_word'(got.dest));
                    check_field("wrote_reg", mse_pkg::t_word'(want.wrote),
                                mse_pkg::t_word'(got.wrote));
                    check_field("result_value", want.value, got.value);
                    check_field("stored", mse_pkg::t_word'(want.stored),
                                mse_pkg::t_word'(got.stored));
                end
            end
            if (i_in_valid && i_in_ready)
                writeback_q.push_back(execute_word(i_in_data));
        end
        o_fail_count <= fail_cnt;
        o_pending    <= writeback_q.size();
        o_checked    <= checked_cnt;
    end

endmodule

// ===== tb/mips_subset_execute_tb.sv =====
// top of the mips subset execute testbench: clock, reset, instruction stream
// and result back-pressure, verdict from the checker's failure count
// depends on mse_pkg, mips_subset_execute and mips_subset_execute_checker

module mips_subset_execute_tb;

    localparam int              RANDOM_WORDS   = 1400;
    localparam int              CYCLE_LIMIT    = 300000;
    localparam int              HOLD_AT_RESULT = 500;
    localparam int              HOLD_CYCLES    = 250;
    localparam mse_pkg::t_code6 OP_UNKNOWN     = 6'h3F;

    typedef enum int {
        K_ADD, K_AND, K_OR, K_NOR, K_SLL, K_ADDI, K_ANDI, K_ORI, K_LW, K_SW
    } t_instr_kind;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [47:0] out_data;
    int          fail_count;
    int          pending;
    int          checked;
    int          words_sent = 0;
    int          directed_words = 0;
    int          send_quiet = 0;
    int          cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mips_subset_execute DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (in_valid),
        .s_axis_tready (in_ready),
        .s_axis_tdata  (in_data),
        .m_axis_tvalid (out_valid),
        .m_axis_tready (out_ready),
        .m_axis_tdata  (out_data)
    );

    mips_subset_execute_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    function automatic mse_pkg::t_word enc_rtype(input mse_pkg::t_code6 funct,
                                                 input mse_pkg::t_reg_idx rs,
                                                 input mse_pkg::t_reg_idx rt,
                                                 input mse_pkg::t_reg_idx rd,
                                                 input logic [4:0] shamt);
        return {mse_pkg::OP_RTYPE, rs, rt, rd, shamt, funct};
    endfunction

    function automatic mse_pkg::t_word enc_itype(input mse_pkg::t_code6 op,
                                                 input mse_pkg::t_reg_idx rs,
                                                 input mse_pkg::t_reg_idx rt,
                                                 input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // low registers more often so results feed later instructions
    function automatic mse_pkg::t_reg_idx pick_reg();
        return ($urandom_range(0, 9) < 6) ? mse_pkg::t_reg_idx'($urandom_range(0, 7))
                                          : mse_pkg::t_reg_idx'($urandom_range(0, 31));
    endfunction

    function automatic mse_pkg::t_word random_word();
        t_instr_kind       kind;
        mse_pkg::t_reg_idx rs;
        mse_pkg::t_reg_idx rt;
        mse_pkg::t_reg_idx rd;
        logic [4:0]        shamt;
        logic [15:0]       imm;
        int                pick;
        mse_pkg::t_word    w;
        rs    = pick_reg();
        rt    = pick_reg();
        rd    = pick_reg();
        shamt = 5'($urandom_range(0, 31));
        case ($urandom_range(0, 7))
            0:       imm = 16'h0000;
            1:       imm = 16'h7FFF;
            2:       imm = 16'h8000;
            3:       imm = 16'hFFFF;
            default: imm = 16'($urandom_range(0, 16'hFFFF));
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            kind = t_instr_kind'($urandom_range(0, K_SW));
            case (kind)
                K_ADD:  w = enc_rtype(mse_pkg::FN_ADD, rs, rt, rd, shamt);
                K_AND:  w = enc_rtype(mse_pkg::FN_AND, rs, rt, rd, shamt);
                K_OR:   w = enc_rtype(mse_pkg::FN_OR, rs, rt, rd, shamt);
                K_NOR:  w = enc_rtype(mse_pkg::FN_NOR, rs, rt, rd, shamt);
                K_SLL:  w = enc_rtype(mse_pkg::FN_SLL, rs, rt, rd, shamt);
                K_ADDI: w = enc_itype(mse_pkg::OP_ADDI, rs, rt, imm);
                K_ANDI: w = enc_itype(mse_pkg::OP_ANDI, rs, rt, imm);
                K_ORI:  w = enc_itype(mse_pkg::OP_ORI, rs, rt, imm);
                K_LW:   w = enc_itype(mse_pkg::OP_LW, rs, rt, imm);
                default: w = enc_itype(mse_pkg::OP_SW, rs, rt, imm);
            endcase
        end else if (pick < 85) begin
            w = mse_pkg::SYSCALL_WORD;
        end else if (pick < 92) begin
            // r-type with any funct, mostly unsupported ones
            w = enc_rtype(mse_pkg::t_code6'($urandom_range(0, 63)), rs, rt, rd, shamt);
        end else begin
            w = $urandom();
        end
        return w;
    endfunction

    task automatic send_word(input mse_pkg::t_word w);
        int gap;
        if (send_quiet > 0) begin
            send_quiet--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 12);
            if ($urandom_range(0, 39) == 0)
                send_quiet = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-extended immediate, then the extreme signed immediates
        send_word(enc_itype(mse_pkg::OP_ORI, 5'd0, 5'd1, 16'hFFFF));
        send_word(enc_itype(mse_pkg::OP_ADDI, 5'd0, 5'd2, 16'h8000));
        send_word(enc_itype(mse_pkg::OP_ADDI, 5'd0, 5'd3, 16'h7FFF));
        send_word(enc_rtype(mse_pkg::FN_SLL, 5'd0, 5'd1, 5'd4, 5'd16));
        send_word(enc_rtype(mse_pkg::FN_OR, 5'd4, 5'd1, 5'd5, 5'd0));      // all ones
        send_word(enc_rtype(mse_pkg::FN_ADD, 5'd5, 5'd5, 5'd6, 5'd0));     // add wraps
        send_word(enc_itype(mse_pkg::OP_ADDI, 5'd5, 5'd8, 16'h0001));     // addi wraps
        send_word(enc_rtype(mse_pkg::FN_AND, 5'd5, 5'd2, 5'd9, 5'd0));
        send_word(enc_rtype(mse_pkg::FN_NOR, 5'd0, 5'd0, 5'd10, 5'd0));
        send_word(enc_rtype(mse_pkg::FN_NOR, 5'd4, 5'd1, 5'd11, 5'd0));
        send_word(enc_itype(mse_pkg::OP_ANDI, 5'd5, 5'd12, 16'hFFFF));
        // rs ignored, max shift; then shamt ignored
        send_word(enc_rtype(mse_pkg::FN_SLL, 5'd31, 5'd5, 5'd13, 5'd31));
        send_word(enc_rtype(mse_pkg::FN_ADD, 5'd1, 5'd1, 5'd14, 5'd31));
        // writes to register zero dropped
        send_word(enc_itype(mse_pkg::OP_ORI, 5'd5, 5'd0, 16'h1234));
        send_word(enc_rtype(mse_pkg::FN_ADD, 5'd5, 5'd5, 5'd0, 5'd0));
        send_word(enc_itype(mse_pkg::OP_SW, 5'd0, 5'd5, 16'hFFFF));       // address -1 wraps
        send_word(enc_itype(mse_pkg::OP_SW, 5'd4, 5'd6, 16'h0005));       // big base wraps
        send_word(enc_itype(mse_pkg::OP_LW, 5'd0, 5'd15, 16'hFFFF));
        send_word(enc_itype(mse_pkg::OP_LW, 5'd31, 5'd16, 16'h0005));
        send_word(enc_itype(mse_pkg::OP_LW, 5'd0, 5'd0, 16'h0005));       // load to zero
        send_word('0);                                                     // all-zero word
        send_word(mse_pkg::SYSCALL_WORD);
        send_word(enc_itype(OP_UNKNOWN, 5'd31, 5'd31, 16'hFFFF));
        // near-syscall
        send_word(enc_rtype(mse_pkg::SYSCALL_WORD[5:0], 5'd0, 5'd0, 5'd1, 5'd0));
        directed_words = words_sent;

        repeat (RANDOM_WORDS) send_word(random_word());
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d instruction words sent, %0d directed, the rest random ops, syscalls",
                 words_sent, directed_words);
        $display("and stray encodings; %0d results checked, output held off %0d cycles once",
                 checked, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // result side: random stalls, quiet stretches and one long hold-off
    initial begin
        int gap;
        int quiet;
        int results;
        quiet   = 0;
        results = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (quiet > 0) begin
                quiet--;
                gap = 0;
            end else begin
                gap = $urandom_range(0, 12);
                if ($urandom_range(0, 39) == 0)
                    quiet = $urandom_range(20, 60);
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            results++;
            if (results == HOLD_AT_RESULT) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run stopped after %0d cycles", $time, CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
